// File: rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Field widths, command and status codes, and the controller interface types.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int CMD_W  = 2;
  localparam int HID_W  = 10;
  localparam int HGEN_W = 16;
  localparam int STS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_VALIDATE = 2'd1,
    CMD_RELEASE  = 2'd2
  } command_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK      = 2'd0,
    STS_INVALID = 2'd1,
    STS_NO_FREE = 2'd2
  } status_t;

  typedef struct packed {
    logic accept;
    logic exec_commit;
    logic agen_read;
    logic agen_commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic reuse;
    logic slot_free;
  } ctrl_sts_t;

endpackage

// File: rtl/gha_in_if.sv
// ----------------------------------------------------------------------------
// Handle request channel
// Valid/ready channel carrying one allocate, validate or release request.
// ----------------------------------------------------------------------------
interface gha_in_if;
  logic                       valid;
  logic                       ready;
  logic [gha_pkg::CMD_W-1:0]  command;
  logic [gha_pkg::HID_W-1:0]  handle_id;
  logic [gha_pkg::HGEN_W-1:0] handle_gen;

  modport source (output valid, command, handle_id, handle_gen, input ready);
  modport sink   (input valid, command, handle_id, handle_gen, output ready);
endinterface

// File: rtl/gha_out_if.sv
// ----------------------------------------------------------------------------
// Handle result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface gha_out_if;
  logic                       valid;
  logic                       ready;
  logic [gha_pkg::STS_W-1:0]  status;
  logic [gha_pkg::HID_W-1:0]  result_id;
  logic [gha_pkg::HGEN_W-1:0] result_gen;

  modport source (output valid, status, result_id, result_gen, input ready);
  modport sink   (input valid, status, result_id, result_gen, output ready);
endinterface

// File: rtl/gha_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered, enable-held read data.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/gha_ctrl.sv
// ----------------------------------------------------------------------------
// Handle allocator controller
// Sequences accept, execute and generation lookup for reused ids.
// ----------------------------------------------------------------------------
module gha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gha_pkg::ctrl_sts_t sts,
  output gha_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_AGEN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.accept   = 1'b1;
          state_nxt    = ST_EXEC;
          in_ready_nxt = 1'b0;
        end
      end
      ST_EXEC: begin
        if (sts.reuse) begin
          cmd.agen_read = 1'b1;
          state_nxt     = ST_AGEN;
        end else if (sts.slot_free) begin
          cmd.exec_commit = 1'b1;
          state_nxt       = ST_IDLE;
          in_ready_nxt    = 1'b1;
        end
      end
      ST_AGEN: begin
        if (sts.slot_free) begin
          cmd.agen_commit = 1'b1;
          state_nxt       = ST_IDLE;
          in_ready_nxt    = 1'b1;
        end
      end
      default: begin
        state_nxt    = ST_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

// File: rtl/gha_datapath.sv
// ----------------------------------------------------------------------------
// Handle allocator datapath
// Generation table, free id queue, counters and the result register.
// ----------------------------------------------------------------------------
module gha_datapath #(
  parameter int MAX_HANDLES = 1024,
  parameter int GEN_BITS    = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gha_pkg::ctrl_cmd_t         cmd,
  output gha_pkg::ctrl_sts_t         sts,
  input  logic [gha_pkg::CMD_W-1:0]  in_command,
  input  logic [gha_pkg::HID_W-1:0]  in_handle_id,
  input  logic [gha_pkg::HGEN_W-1:0] in_handle_gen,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gha_pkg::STS_W-1:0]  out_status,
  output logic [gha_pkg::HID_W-1:0]  out_result_id,
  output logic [gha_pkg::HGEN_W-1:0] out_result_gen
);

  localparam int ID_W   = $clog2(MAX_HANDLES);
  localparam int CNT_W  = $clog2(MAX_HANDLES + 1);
  localparam int IDX_W  = (ID_W > gha_pkg::HID_W) ? ID_W : gha_pkg::HID_W;
  localparam int CMPI_W = (CNT_W > gha_pkg::HID_W) ? CNT_W : gha_pkg::HID_W;
  localparam int CMP_W  = (GEN_BITS > gha_pkg::HGEN_W) ? GEN_BITS : gha_pkg::HGEN_W;

  localparam logic [ID_W-1:0]  LAST_ID = ID_W'(MAX_HANDLES - 1);
  localparam logic [CNT_W-1:0] FULL    = CNT_W'(MAX_HANDLES);

  logic [gha_pkg::CMD_W-1:0]  cmd_r;
  logic [gha_pkg::HID_W-1:0]  id_r;
  logic [gha_pkg::HGEN_W-1:0] gen_r;

  logic [ID_W-1:0]  head_r, tail_r;
  logic [CNT_W-1:0] count_r, issued_r;

  logic                       out_valid_r;
  logic [gha_pkg::STS_W-1:0]  status_r;
  logic [gha_pkg::HID_W-1:0]  result_id_r;
  logic [gha_pkg::HGEN_W-1:0] result_gen_r;

  logic [GEN_BITS-1:0] gen_rdata, gen_wdata, gen_new;
  logic [ID_W-1:0]     gen_raddr, gen_waddr, q_rdata;
  logic                gen_re, gen_we, gen_wr;
  logic                q_wr;

  logic [IDX_W-1:0]  in_id_ext, id_ext, q_id_ext, issued_id_ext;
  logic [CMP_W-1:0]  stored_ext, req_gen_ext, new_ext;
  logic              match, id_issued, reuse;
  logic [gha_pkg::STS_W-1:0]  res_status;
  logic [gha_pkg::HID_W-1:0]  res_id;
  logic [gha_pkg::HGEN_W-1:0] res_gen;

  assign in_id_ext     = IDX_W'(in_handle_id);
  assign id_ext        = IDX_W'(id_r);
  assign q_id_ext      = IDX_W'(q_rdata);
  assign issued_id_ext = IDX_W'(issued_r[ID_W-1:0]);

  assign gen_re    = cmd.accept || cmd.agen_read;
  assign gen_raddr = cmd.agen_read ? q_rdata : in_id_ext[ID_W-1:0];

  gha_ram #(.WIDTH(GEN_BITS), .DEPTH(MAX_HANDLES)) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .re    (gen_re),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  gha_ram #(.WIDTH(ID_W), .DEPTH(MAX_HANDLES)) u_queue_ram (
    .clk   (clk),
    .we    (cmd.exec_commit && q_wr),
    .waddr (tail_r),
    .wdata (id_ext[ID_W-1:0]),
    .re    (cmd.accept),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  assign gen_new     = gen_rdata + GEN_BITS'(1);
  assign stored_ext  = CMP_W'(gen_rdata);
  assign new_ext     = CMP_W'(gen_new);
  assign req_gen_ext = CMP_W'(gen_r);
  assign match       = (stored_ext == req_gen_ext);
  assign id_issued   = (CMPI_W'(id_r) < CMPI_W'(issued_r));
  assign gen_we      = cmd.exec_commit && gen_wr;

  always_comb begin
    reuse      = 1'b0;
    gen_wr     = 1'b0;
    q_wr       = 1'b0;
    gen_waddr  = id_ext[ID_W-1:0];
    gen_wdata  = gen_new;
    res_status = gha_pkg::STS_INVALID;
    res_id     = id_r;
    res_gen    = '0;
    case (cmd_r)
      gha_pkg::CMD_ALLOC: begin
        if (count_r != '0) begin
          reuse      = 1'b1;
          res_status = gha_pkg::STS_OK;
          res_id     = q_id_ext[gha_pkg::HID_W-1:0];
          res_gen    = stored_ext[gha_pkg::HGEN_W-1:0];
        end else if (issued_r != FULL) begin
          gen_wr     = 1'b1;
          gen_waddr  = issued_r[ID_W-1:0];
          gen_wdata  = '0;
          res_status = gha_pkg::STS_OK;
          res_id     = issued_id_ext[gha_pkg::HID_W-1:0];
        end else begin
          res_status = gha_pkg::STS_NO_FREE;
          res_id     = '0;
        end
      end
      gha_pkg::CMD_VALIDATE: begin
        if (id_issued) begin
          res_status = match ? gha_pkg::STS_OK : gha_pkg::STS_INVALID;
          res_gen    = stored_ext[gha_pkg::HGEN_W-1:0];
        end
      end
      gha_pkg::CMD_RELEASE: begin
        if (id_issued) begin
          res_gen = stored_ext[gha_pkg::HGEN_W-1:0];
          if (match && (count_r != FULL)) begin
            gen_wr     = 1'b1;
            q_wr       = 1'b1;
            res_status = gha_pkg::STS_OK;
            res_gen    = new_ext[gha_pkg::HGEN_W-1:0];
          end
        end
      end
      default: begin
        res_status = gha_pkg::STS_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_command;
      id_r  <= in_handle_id;
      gen_r <= in_handle_gen;
    end
    if (cmd.exec_commit || cmd.agen_commit) begin
      status_r     <= res_status;
      result_id_r  <= res_id;
      result_gen_r <= res_gen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      issued_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec_commit && gen_wr && !q_wr) begin
        issued_r <= issued_r + CNT_W'(1);
      end
      if (cmd.exec_commit && q_wr) begin
        tail_r  <= (tail_r == LAST_ID) ? '0 : tail_r + ID_W'(1);
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.agen_commit) begin
        head_r  <= (head_r == LAST_ID) ? '0 : head_r + ID_W'(1);
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.exec_commit || cmd.agen_commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.reuse     = reuse;
  assign sts.slot_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_result_id  = result_id_r;
  assign out_result_gen = result_gen_r;

endmodule

// File: rtl/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// Generational handle allocator
// Allocates, validates and releases id/generation handles, reusing released
// ids in first-in first-out order.
//
//   Channel   Direction  Handshake              Payload
//   in_chan   sink       valid/ready            command, handle_id, handle_gen
//   out_chan  source     valid/ready            status, result_id, result_gen
//
// Validate, release and fresh allocate requests are accepted in the idle
// state and finish in the execute state; a reusing allocate adds a lookup
// state, as its queue and table reads chain through registered RAM ports.
// A finished result waits in the output register; the next request is taken
// meanwhile and only stalls at its end if that register is still occupied.
// Reset clears the counters and pointers directly; no clearing pass runs.
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
  parameter int MAX_HANDLES = 1024,
  parameter int GEN_BITS    = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  gha_in_if.sink    in_chan,
  gha_out_if.source out_chan
);

  gha_pkg::ctrl_cmd_t ctrl_cmd;
  gha_pkg::ctrl_sts_t ctrl_sts;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (ctrl_sts),
    .cmd      (ctrl_cmd)
  );

  gha_datapath #(
    .MAX_HANDLES (MAX_HANDLES),
    .GEN_BITS    (GEN_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (ctrl_cmd),
    .sts            (ctrl_sts),
    .in_command     (in_chan.command),
    .in_handle_id   (in_chan.handle_id),
    .in_handle_gen  (in_chan.handle_gen),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_status     (out_chan.status),
    .out_result_id  (out_chan.result_id),
    .out_result_gen (out_chan.result_gen)
  );

endmodule

// File: rtl/gha_checker.sv
// ----------------------------------------------------------------------------
// Handle allocator port checker
// Checks request and result ordering and result encoding at the ports.
// ----------------------------------------------------------------------------
module gha_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [gha_pkg::STS_W-1:0]  out_status,
  input logic [gha_pkg::HID_W-1:0]  out_result_id,
  input logic [gha_pkg::HGEN_W-1:0] out_result_gen
);

  logic       in_fire, out_fire;
  logic [1:0] pending_r;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 2'(in_fire) - 2'(out_fire);
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_result_id) && $stable(out_result_gen))
    else $error("Result changed while stalled");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("Result delivered without an outstanding request");

  a_bounded_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("More requests outstanding than the block can hold");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("Request taken while the previous one was still in work");

  a_no_free_encoding: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == gha_pkg::STS_NO_FREE |->
    out_result_id == '0 && out_result_gen == '0)
    else $error("Allocation failure carries a non-zero handle");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_result_id  (out_chan.result_id),
  .out_result_gen (out_chan.result_gen)
);
